/* sv/polarization_matrix_apply_defines.svh */
// Assertion macros for the polarization matrix apply block.
// Included by the modules that carry assertions; no other dependencies.
`ifndef POLARIZATION_MATRIX_APPLY_DEFINES_SVH
`define POLARIZATION_MATRIX_APPLY_DEFINES_SVH

// Clocked check, masked while reset is high
`define PMA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds through reset
`define PMA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* sv/pma_pkg.sv */
// Types shared by the polarization matrix apply pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pma_pkg;

   // Packed complex word: signed real part high, signed imaginary part low
   typedef struct packed {
      logic signed [15:0] re;
      logic signed [15:0] im;
   } cplx_type;

   // Input transfer
   typedef struct packed {
      logic [31:0] in_prod_0;
      logic [31:0] in_prod_1;
      logic [31:0] in_prod_2;
      logic [31:0] in_prod_3;
      logic [31:0] jones_00;
      logic [31:0] jones_01;
      logic [31:0] jones_10;
      logic [31:0] jones_11;
      logic        conj_mode;
      logic        last_channel;
   } req_type;

   // Result transfer
   typedef struct packed {
      logic [31:0] out_prod_0;
      logic [31:0] out_prod_1;
      logic [31:0] out_prod_2;
      logic [31:0] out_prod_3;
      logic        last_out;
   } rsp_type;

   // Operands of one output: m0*a + m1*b
   typedef struct packed {
      cplx_type m0;
      cplx_type a;
      cplx_type m1;
      cplx_type b;
   } pair_type;

   // Stage 1: operands routed per output
   typedef struct packed {
      pair_type [3:0] pair;
      logic           conj;
      logic           last;
   } route_type;

   // Real partial products of one output (rr = m.re*v.re, ri = m.re*v.im, ...)
   typedef struct packed {
      logic signed [31:0] rr0;
      logic signed [31:0] ii0;
      logic signed [31:0] ri0;
      logic signed [31:0] ir0;
      logic signed [31:0] rr1;
      logic signed [31:0] ii1;
      logic signed [31:0] ri1;
      logic signed [31:0] ir1;
   } prod_set_type;

   // Stage 2: all partial products
   typedef struct packed {
      prod_set_type [3:0] prod;
      logic               conj;
      logic               last;
   } prod_type;

   // Full precision sum of one output, 26 fraction bits
   typedef struct packed {
      logic signed [33:0] re;
      logic signed [33:0] im;
   } wide_cplx_type;

   // Stage 3: exact sums
   typedef struct packed {
      wide_cplx_type [3:0] acc;
      logic                last;
   } sum_type;

endpackage

`default_nettype wire

/* sv/pma_route.sv */
// Stage 1: unpacks the input transfer and routes matrix and product
// operands to each of the four outputs by mode. Depends on pma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pma_route (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               up_valid,
   input  wire pma_pkg::req_type   up_data,
   output logic                    up_stall,
   output logic                    dn_valid,
   output pma_pkg::route_type      dn_data,
   input  wire logic               dn_stall
);
   import pma_pkg::*;

   logic      valid_ff;
   route_type data_ff;
   route_type data_in;
   cplx_type  v0, v1, v2, v3, m00, m01, m10, m11;

   // Operand selection
   always_comb begin
      v0  = cplx_type'(up_data.in_prod_0);
      v1  = cplx_type'(up_data.in_prod_1);
      v2  = cplx_type'(up_data.in_prod_2);
      v3  = cplx_type'(up_data.in_prod_3);
      m00 = cplx_type'(up_data.jones_00);
      m01 = cplx_type'(up_data.jones_01);
      m10 = cplx_type'(up_data.jones_10);
      m11 = cplx_type'(up_data.jones_11);
      data_in.conj = ~up_data.conj_mode;
      data_in.last = up_data.last_channel;
      if (up_data.conj_mode) begin
         // left multiply
         data_in.pair[0] = '{m0: m00, a: v0, m1: m01, b: v3};
         data_in.pair[3] = '{m0: m00, a: v2, m1: m01, b: v1};
         data_in.pair[2] = '{m0: m10, a: v0, m1: m11, b: v3};
         data_in.pair[1] = '{m0: m10, a: v2, m1: m11, b: v1};
      end else begin
         // conjugated matrix
         data_in.pair[0] = '{m0: m00, a: v0, m1: m01, b: v2};
         data_in.pair[3] = '{m0: m10, a: v0, m1: m11, b: v2};
         data_in.pair[2] = '{m0: m00, a: v3, m1: m01, b: v1};
         data_in.pair[1] = '{m0: m10, a: v3, m1: m11, b: v1};
      end
   end

   // Stage holds only while full and stalled downstream
   assign up_stall = valid_ff & dn_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_stall) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

/* sv/pma_mult.sv */
// Stage 2: 32 signed 16x16 multipliers forming all real partial products.
// Depends on pma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pma_mult (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               up_valid,
   input  wire pma_pkg::route_type up_data,
   output logic                    up_stall,
   output logic                    dn_valid,
   output pma_pkg::prod_type       dn_data,
   input  wire logic               dn_stall
);
   import pma_pkg::*;

   logic     valid_ff;
   prod_type data_ff;
   prod_type data_in;

   // Partial products, one set per output
   always_comb begin
      data_in.conj = up_data.conj;
      data_in.last = up_data.last;
      for (int k = 0; k < 4; k++) begin
         data_in.prod[k].rr0 = 32'(up_data.pair[k].m0.re) * 32'(up_data.pair[k].a.re);
         data_in.prod[k].ii0 = 32'(up_data.pair[k].m0.im) * 32'(up_data.pair[k].a.im);
         data_in.prod[k].ri0 = 32'(up_data.pair[k].m0.re) * 32'(up_data.pair[k].a.im);
         data_in.prod[k].ir0 = 32'(up_data.pair[k].m0.im) * 32'(up_data.pair[k].a.re);
         data_in.prod[k].rr1 = 32'(up_data.pair[k].m1.re) * 32'(up_data.pair[k].b.re);
         data_in.prod[k].ii1 = 32'(up_data.pair[k].m1.im) * 32'(up_data.pair[k].b.im);
         data_in.prod[k].ri1 = 32'(up_data.pair[k].m1.re) * 32'(up_data.pair[k].b.im);
         data_in.prod[k].ir1 = 32'(up_data.pair[k].m1.im) * 32'(up_data.pair[k].b.re);
      end
   end

   assign up_stall = valid_ff & dn_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_stall) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

/* sv/pma_sum.sv */
// Stage 3: four-term signed sums per output part, with the sign of the
// imaginary cross terms set by mode. Depends on pma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pma_sum (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               up_valid,
   input  wire pma_pkg::prod_type  up_data,
   output logic                    up_stall,
   output logic                    dn_valid,
   output pma_pkg::sum_type        dn_data,
   input  wire logic               dn_stall
);
   import pma_pkg::*;

   logic    valid_ff;
   sum_type data_ff;
   sum_type data_in;

   // Conjugated form: re = rr + ii, im = ri - ir; else re = rr - ii, im = ri + ir
   always_comb begin
      data_in.last = up_data.last;
      for (int k = 0; k < 4; k++) begin
         if (up_data.conj) begin
            data_in.acc[k].re = 34'(up_data.prod[k].rr0) + 34'(up_data.prod[k].ii0)
                              + 34'(up_data.prod[k].rr1) + 34'(up_data.prod[k].ii1);
            data_in.acc[k].im = 34'(up_data.prod[k].ri0) - 34'(up_data.prod[k].ir0)
                              + 34'(up_data.prod[k].ri1) - 34'(up_data.prod[k].ir1);
         end else begin
            data_in.acc[k].re = 34'(up_data.prod[k].rr0) - 34'(up_data.prod[k].ii0)
                              + 34'(up_data.prod[k].rr1) - 34'(up_data.prod[k].ii1);
            data_in.acc[k].im = 34'(up_data.prod[k].ri0) + 34'(up_data.prod[k].ir0)
                              + 34'(up_data.prod[k].ri1) + 34'(up_data.prod[k].ir1);
         end
      end
   end

   assign up_stall = valid_ff & dn_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_stall) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

/* sv/pma_round.sv */
// Stage 4: round half up at 13 fraction bits, saturate to 16 bits and
// pack the result into the output register. Depends on pma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pma_round (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               up_valid,
   input  wire pma_pkg::sum_type   up_data,
   output logic                    up_stall,
   output logic                    dn_valid,
   output pma_pkg::rsp_type        dn_data,
   input  wire logic               dn_stall
);
   import pma_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;
   rsp_type data_in;

   // Add half an LSB, floor shift, clamp to the signed 16-bit range
   function automatic logic [15:0] round_sat(input logic signed [33:0] x);
      logic signed [34:0] t;
      logic signed [21:0] q;
      t = 35'(x) + 35'sd4096;
      q = 22'(t >>> 13);
      if (q > 22'sd32767) begin
         round_sat = 16'h7fff;
      end else if (q < -22'sd32768) begin
         round_sat = 16'h8000;
      end else begin
         round_sat = q[15:0];
      end
   endfunction

   always_comb begin
      data_in.out_prod_0 = {round_sat(up_data.acc[0].re), round_sat(up_data.acc[0].im)};
      data_in.out_prod_1 = {round_sat(up_data.acc[1].re), round_sat(up_data.acc[1].im)};
      data_in.out_prod_2 = {round_sat(up_data.acc[2].re), round_sat(up_data.acc[2].im)};
      data_in.out_prod_3 = {round_sat(up_data.acc[3].re), round_sat(up_data.acc[3].im)};
      data_in.last_out   = up_data.last;
   end

   assign up_stall = valid_ff & dn_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_stall) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

/* sv/polarization_matrix_apply.sv */
// Top level of the polarization matrix apply block: route, multiply,
// sum and round stages. Depends on pma_pkg and the assertion header.
//
//   channel | valid     | stall     | payload
//   input   | req_valid | req_stall | req_data (pma_pkg::req_type)
//   result  | rsp_valid | rsp_stall | rsp_data (pma_pkg::rsp_type)
//
// One item per cycle sustained while rsp_stall stays low; each input transfer
// passes the four register stages in order (operand routing, the 32
// multipliers, the four-term adders, rounding).
// Each stage holds only while it is full and the stage after it stalls, so
// empty stages keep filling while a result waits.
// Reset clears the stage valid bits; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "polarization_matrix_apply_defines.svh"

module polarization_matrix_apply (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire pma_pkg::req_type  req_data,
   output logic                   req_stall,
   output logic                   rsp_valid,
   output pma_pkg::rsp_type       rsp_data,
   input  wire logic              rsp_stall
);
   import pma_pkg::*;

   logic      route_valid, route_stall;
   route_type route_data;
   logic      mult_valid, mult_stall;
   prod_type  mult_data;
   logic      sum_valid, sum_stall;
   sum_type   sum_data;

   pma_route u_route (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_data  (req_data),
      .up_stall (req_stall),
      .dn_valid (route_valid),
      .dn_data  (route_data),
      .dn_stall (route_stall)
   );

   pma_mult u_mult (
      .clock    (clock),
      .reset    (reset),
      .up_valid (route_valid),
      .up_data  (route_data),
      .up_stall (route_stall),
      .dn_valid (mult_valid),
      .dn_data  (mult_data),
      .dn_stall (mult_stall)
   );

   pma_sum u_sum (
      .clock    (clock),
      .reset    (reset),
      .up_valid (mult_valid),
      .up_data  (mult_data),
      .up_stall (mult_stall),
      .dn_valid (sum_valid),
      .dn_data  (sum_data),
      .dn_stall (sum_stall)
   );

   pma_round u_round (
      .clock    (clock),
      .reset    (reset),
      .up_valid (sum_valid),
      .up_data  (sum_data),
      .up_stall (sum_stall),
      .dn_valid (rsp_valid),
      .dn_data  (rsp_data),
      .dn_stall (rsp_stall)
   );

   // With no result stall in between, an accepted transfer reaches the output register with its last flag
   property p_latency;
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
         |=> (rsp_valid && rsp_data.last_out == $past(req_data.last_channel, 4));
   endproperty

   // Backpressure at the input only ever comes from the result side
   `PMA_ASSERT(a_stall_source, req_stall |-> rsp_stall, "input stalled without result stall")

   `PMA_ASSERT(a_latency, p_latency, "item lost or late in pipeline")

   // Synchronous reset empties the pipeline
   `PMA_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid right after reset")

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking bench for polarization_matrix_apply: random and directed channels,
// each checked against a bit-exact predictor of the 2x2 complex conversion.
// Depends on pma_pkg and the polarization_matrix_apply RTL.
`timescale 1ns / 1ps

module testbench;
   import pma_pkg::*;

   localparam int RANDOM_PER_MODE = 434;
   localparam int HOLD_CYCLES     = 150;
   localparam int SETTLE_CYCLES   = 10;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int MAX_PRINTED     = 40;

   // Q2.13 unit values and extreme words
   localparam logic [31:0] RE_ONE = 32'h2000_0000;
   localparam logic [31:0] IM_ONE = 32'h0000_2000;
   localparam logic [31:0] W_MAX  = 32'h7FFF_7FFF;
   localparam logic [31:0] W_MIN  = 32'h8000_8000;
   localparam logic [31:0] LSB_RE = 32'h0001_0000;

   // Who idles how often during a stretch of traffic
   typedef enum logic [1:0] {
      IDLE_RECV_HEAVY,
      IDLE_SEND_HEAVY,
      IDLE_OFF
   } idle_mode_type;

   typedef struct {
      req_type       channel;
      idle_mode_type mode;
      bit            drain_first;
   } pending_type;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   req_type       req_data  = '0;
   logic          req_stall;
   logic          rsp_valid;
   rsp_type       rsp_data;
   logic          rsp_stall = 1'b0;

   pending_type   channels_to_send[$];
   rsp_type       expected_products[$];
   idle_mode_type idle_mode      = IDLE_RECV_HEAVY;
   int unsigned   items_accepted = 0;
   int unsigned   results_checked = 0;
   int unsigned   hold_start_at  = 0;
   int unsigned   hold_left      = 0;
   logic          hold_armed     = 1'b1;
   int unsigned   error_count    = 0;
   int unsigned   cycle_count    = 0;
   int unsigned   left_count     = 0;

   polarization_matrix_apply uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // Round half up from 13 fraction bits, then clamp to signed 16 bits
   function automatic logic [15:0] round_saturate(longint acc);
      longint q;
      q = (acc + 64'sd4096) >>> 13;
      if (q > 32767)
         q = 32767;
      else if (q < -32768)
         q = -32768;
      return q[15:0];
   endfunction

   // m0*a + m1*b, matrix terms conjugated when conj is set
   function automatic logic [31:0] pair_product(logic [31:0] m0, logic [31:0] a,
                                                 logic [31:0] m1, logic [31:0] b,
                                                 logic conj);
      cplx_type cm0, ca, cm1, cb;
      longint   m0_im, m1_im, sum_re, sum_im;
      cm0 = m0;
      ca  = a;
      cm1 = m1;
      cb  = b;
      m0_im = conj ? -longint'(cm0.im) : longint'(cm0.im);
      m1_im = conj ? -longint'(cm1.im) : longint'(cm1.im);
      sum_re = longint'(cm0.re) * ca.re - m0_im * ca.im
             + longint'(cm1.re) * cb.re - m1_im * cb.im;
      sum_im = longint'(cm0.re) * ca.im + m0_im * ca.re
             + longint'(cm1.re) * cb.im + m1_im * cb.re;
      return {round_saturate(sum_re), round_saturate(sum_im)};
   endfunction

   function automatic rsp_type convert_channel(req_type ch);
      rsp_type r;
      if (ch.conj_mode) begin
         // matrix from the left
         r.out_prod_0 = pair_product(ch.jones_00, ch.in_prod_0, ch.jones_01, ch.in_prod_3, 1'b0);
         r.out_prod_3 = pair_product(ch.jones_00, ch.in_prod_2, ch.jones_01, ch.in_prod_1, 1'b0);
         r.out_prod_2 = pair_product(ch.jones_10, ch.in_prod_0, ch.jones_11, ch.in_prod_3, 1'b0);
         r.out_prod_1 = pair_product(ch.jones_10, ch.in_prod_2, ch.jones_11, ch.in_prod_1, 1'b0);
      end else begin
         // conjugated matrix
         r.out_prod_0 = pair_product(ch.jones_00, ch.in_prod_0, ch.jones_01, ch.in_prod_2, 1'b1);
         r.out_prod_3 = pair_product(ch.jones_10, ch.in_prod_0, ch.jones_11, ch.in_prod_2, 1'b1);
         r.out_prod_2 = pair_product(ch.jones_00, ch.in_prod_3, ch.jones_01, ch.in_prod_1, 1'b1);
         r.out_prod_1 = pair_product(ch.jones_10, ch.in_prod_3, ch.jones_11, ch.in_prod_1, 1'b1);
      end
      r.last_out = ch.last_channel;
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic req_type make_channel(logic [31:0] p0, logic [31:0] p1,
                                            logic [31:0] p2, logic [31:0] p3,
                                            logic [31:0] j00, logic [31:0] j01,
                                            logic [31:0] j10, logic [31:0] j11,
                                            logic conj, logic last);
      req_type ch;
      ch.in_prod_0    = p0;
      ch.in_prod_1    = p1;
      ch.in_prod_2    = p2;
      ch.in_prod_3    = p3;
      ch.jones_00     = j00;
      ch.jones_01     = j01;
      ch.jones_10     = j10;
      ch.jones_11     = j11;
      ch.conj_mode    = conj;
      ch.last_channel = last;
      return ch;
   endfunction

   // One signed part: full range, small, around unit scale, or an extreme
   function automatic logic [15:0] random_part();
      int v;
      case ($urandom_range(3))
         0: v = $urandom;
         1: v = int'($urandom_range(1023)) - 512;
         2: v = int'($urandom_range(16384)) - 8192;
         default: begin
            case ($urandom_range(3))
               0: v = 32'h7FFF;
               1: v = 32'h8000;
               2: v = 0;
               default: v = 32'hFFFF;
            endcase
         end
      endcase
      return v[15:0];
   endfunction

   function automatic logic [31:0] random_word();
      return {random_part(), random_part()};
   endfunction

   task automatic queue_channel(req_type ch, idle_mode_type mode, bit drain);
      pending_type p;
      p.channel     = ch;
      p.mode        = mode;
      p.drain_first = drain;
      channels_to_send.push_back(p);
   endtask

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("ERROR %0t: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      logic sent;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         sent = req_valid && !req_stall;
         if (sent) begin
            expected_products.push_back(convert_channel(req_data));
            void'(channels_to_send.pop_front());
            items_accepted <= items_accepted + 1;
            if (req_data.conj_mode)
               left_count <= left_count + 1;
         end
         if (req_valid && !sent) begin
            // stalled transfer keeps its payload
         end else if (channels_to_send.size() == 0) begin
            req_valid <= 1'b0;
         end else if (channels_to_send[0].drain_first && expected_products.size() != 0) begin
            req_valid <= 1'b0;
         end else if ($urandom_range(99) < send_idle_pct(channels_to_send[0].mode)) begin
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_data  <= channels_to_send[0].channel;
            idle_mode <= channels_to_send[0].mode;
         end
      end
   end

   function automatic int unsigned send_idle_pct(idle_mode_type mode);
      case (mode)
         IDLE_RECV_HEAVY: return 17;
         IDLE_SEND_HEAVY: return 63;
         default:         return 0;
      endcase
   endfunction

   function automatic int unsigned recv_idle_pct(idle_mode_type mode);
      case (mode)
         IDLE_RECV_HEAVY: return 63;
         IDLE_SEND_HEAVY: return 17;
         default:         return 0;
      endcase
   endfunction

   // Long output hold-off, started once a given number of transfers went in
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_armed <= 1'b1;
      end else if (hold_armed && items_accepted >= hold_start_at) begin
         hold_left  <= HOLD_CYCLES;
         hold_armed <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_products.size() == 0) begin
               report_mismatch($sformatf("result %h with nothing expected", rsp_data));
            end else begin
               want = expected_products.pop_front();
               if (rsp_data.out_prod_0 !== want.out_prod_0)
                  report_mismatch($sformatf("out_prod_0 got %h want %h",
                                            rsp_data.out_prod_0, want.out_prod_0));
               if (rsp_data.out_prod_1 !== want.out_prod_1)
                  report_mismatch($sformatf("out_prod_1 got %h want %h",
                                            rsp_data.out_prod_1, want.out_prod_1));
               if (rsp_data.out_prod_2 !== want.out_prod_2)
                  report_mismatch($sformatf("out_prod_2 got %h want %h",
                                            rsp_data.out_prod_2, want.out_prod_2));
               if (rsp_data.out_prod_3 !== want.out_prod_3)
                  report_mismatch($sformatf("out_prod_3 got %h want %h",
                                            rsp_data.out_prod_3, want.out_prod_3));
               if (rsp_data.last_out !== want.last_out)
                  report_mismatch($sformatf("last_out got %b want %b",
                                            rsp_data.last_out, want.last_out));
            end
            results_checked <= results_checked + 1;
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct(idle_mode));
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      idle_mode_type mode;
      logic          conj;
      // Directed: both matrix modes for each pattern
      for (int m = 0; m < 2; m++) begin
         conj = m[0];
         queue_channel(make_channel(0, 0, 0, 0, 0, 0, 0, 0, conj, conj),
                       IDLE_RECV_HEAVY, 0);
         // identity matrix passes products through
         queue_channel(make_channel(32'h1234_5678, 32'h8000_7FFF, 32'hFFFF_0001,
                                    32'h7FFF_8000, RE_ONE, 0, 0, RE_ONE, conj, !conj),
                       IDLE_RECV_HEAVY, 0);
         // saturation at both rails
         queue_channel(make_channel(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX,
                                    conj, 1'b1), IDLE_RECV_HEAVY, 0);
         queue_channel(make_channel(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN,
                                    conj, 1'b0), IDLE_RECV_HEAVY, 0);
         queue_channel(make_channel(W_MAX, W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN, W_MIN,
                                    conj, conj), IDLE_RECV_HEAVY, 0);
         queue_channel(make_channel(32'h7FFF_8000, 32'h8000_7FFF, 32'h7FFF_8000,
                                    32'h8000_7FFF, 32'h8000_7FFF, 32'h7FFF_8000,
                                    32'h8000_7FFF, 32'h7FFF_8000, conj, !conj),
                       IDLE_RECV_HEAVY, 0);
         // exact halves: +0.5 -> 1, -0.5 -> 0, +1.5 -> 2, -1.5 -> -1
         queue_channel(make_channel(32'h1000_F000, 0, 0, 0, LSB_RE, 0, 0, 0, conj, 1'b1),
                       IDLE_RECV_HEAVY, 0);
         queue_channel(make_channel(32'h3000_D000, 0, 0, 32'h0FFF_F001, LSB_RE, 0, 0, LSB_RE,
                                    conj, 1'b0), IDLE_RECV_HEAVY, 0);
         // imaginary matrix terms expose the conjugation
         queue_channel(make_channel(32'h0010_0020, 32'h0030_FFC0, 32'hFF00_0100,
                                    32'h0400_FC00, IM_ONE, 32'h0000_E000, 32'hE000_0000,
                                    IM_ONE, conj, conj), IDLE_RECV_HEAVY, 0);
         // off-diagonal matrix shows the product routing
         queue_channel(make_channel(32'h0001_0002, 32'h0003_0004, 32'h0005_0006,
                                    32'h0007_0008, 0, RE_ONE, RE_ONE, 0, conj, !conj),
                       IDLE_RECV_HEAVY, 0);
      end

      // Random: three idling regimes, the second and third entered with the block drained
      for (int phase = 0; phase < 3; phase++) begin
         mode = (phase == 0) ? IDLE_RECV_HEAVY : (phase == 1) ? IDLE_SEND_HEAVY : IDLE_OFF;
         for (int k = 0; k < RANDOM_PER_MODE; k++)
            queue_channel(make_channel(random_word(), random_word(), random_word(),
                                       random_word(), random_word(), random_word(),
                                       random_word(), random_word(), 1'($urandom_range(1)),
                                       ($urandom_range(7) == 0)),
                          mode, (phase != 0 && k == 0));
      end
      // output hold-off lands in the stretch where the sender never idles
      hold_start_at = channels_to_send.size() - RANDOM_PER_MODE + 100;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (channels_to_send.size() != 0 || req_valid || expected_products.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_products.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_products.size()));

      $display("Sent %0d channels (%0d left-multiply, %0d conjugated), checked %0d results,",
               items_accepted, left_count, items_accepted - left_count, results_checked);
      $display("through directed edge cases, three idling regimes and a long output hold.");
      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("testbench failed");
      end
      $finish;
   end

endmodule
